>>> src/beep_pattern_sequencer_top_macros.svh
// Assertion macros used by the beep pattern sequencer checker.
`ifndef BEEP_PATTERN_SEQUENCER_TOP_MACROS_SVH
`define BEEP_PATTERN_SEQUENCER_TOP_MACROS_SVH

// Clocked assertion that is switched off while reset is held.
`define BPS_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked assertion that also holds while reset is held.
`define BPS_ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

>>> src/bps_pkg.sv
// Shared types and constants of the beep pattern sequencer.
package bps_pkg;

	localparam int QueueDepth = 10;
	localparam int QidxW = $clog2(QueueDepth);
	localparam int QcntW = $clog2(QueueDepth + 1);

	typedef logic [QidxW-1:0] qidx_t;
	typedef logic [QcntW-1:0] qcnt_t;

	localparam logic OP_TICK = 1'b0;
	localparam logic OP_ENQ  = 1'b1;

	typedef enum logic [2:0] {
		PH_INIT      = 3'd0,
		PH_IDLE      = 3'd1,
		PH_DELAY     = 3'd2,
		PH_TURN_ON   = 3'd3,
		PH_BEEPING   = 3'd4,
		PH_TURN_OFF  = 3'd5,
		PH_INTERLUDE = 3'd6
	} phase_t;

	typedef enum logic {
		CS_IDLE,
		CS_EXEC
	} ctl_state_t;

	typedef enum logic [1:0] {
		CL_NONE,
		CL_DELAY,
		CL_WIDTH,
		CL_GAP
	} cnt_load_t;

	typedef struct packed {
		logic [7:0]  times;
		logic [15:0] width;
		logic [15:0] delay;
		logic [15:0] gap;
	} entry_t;

	typedef struct packed {
		logic      capture;
		logic      commit;
		logic      enqueue;
		logic      tick;
		cnt_load_t load;
		logic      buzz_set;
		logic      buzz_clr;
		logic      rep_next;
		logic      pop;
		logic      busy;
	} dp_cmd_t;

	typedef struct packed {
		logic is_enq;
		logic cnt_zero;
		logic q_nonempty;
		logic last_rep;
	} dp_stat_t;

endpackage

>>> src/beep_pattern_sequencer_top.sv
// Top level of the beep pattern sequencer: controller plus datapath.
// A request is captured on transfer, then executed once the result register is free.
// No new request is taken until the last has executed, set by the capture/execute loop;
// a stalled result holds execution of the next item until the result register frees.
// Reset: phase returns to init, the queue is empty, countdown and buzzer state are zero.
// Queue storage is not cleared by reset; only written entries are ever used.
module beep_pattern_sequencer_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        req_valid,
	output logic        req_ready,
	input  logic        opcode,
	input  logic [7:0]  repeat_count,
	input  logic [15:0] on_ticks,
	input  logic [15:0] delay_ticks,
	input  logic [15:0] gap_ticks,
	output logic        rsp_valid,
	input  logic        rsp_ready,
	output logic        buzzer_on,
	output logic        accepted,
	output logic [3:0]  queue_count,
	output logic        busy_res
);
	import bps_pkg::*;

	dp_cmd_t  cmd;
	dp_stat_t stat;

	bps_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bps_datapath u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.stat         (stat),
		.opcode       (opcode),
		.repeat_count (repeat_count),
		.on_ticks     (on_ticks),
		.delay_ticks  (delay_ticks),
		.gap_ticks    (gap_ticks),
		.buzzer_on    (buzzer_on),
		.accepted     (accepted),
		.queue_count  (queue_count),
		.busy_res     (busy_res)
	);

endmodule

>>> src/bps_datapath.sv
// Datapath: request queue, countdown, repetition counter, buzzer and result registers.
module bps_datapath (
	input  logic             clk,
	input  logic             arst_n,
	input  bps_pkg::dp_cmd_t cmd,
	output bps_pkg::dp_stat_t stat,
	input  logic             opcode,
	input  logic [7:0]       repeat_count,
	input  logic [15:0]      on_ticks,
	input  logic [15:0]      delay_ticks,
	input  logic [15:0]      gap_ticks,
	output logic             buzzer_on,
	output logic             accepted,
	output logic [3:0]       queue_count,
	output logic             busy_res
);
	import bps_pkg::*;

	logic   op_q;
	entry_t req_q;
	entry_t mem [QueueDepth];
	entry_t rd_q;
	qidx_t  head_q;
	qidx_t  tail_q;
	qcnt_t  count_q;
	qcnt_t  count_d;
	logic [7:0]  rep_q;
	logic [15:0] cnt_q;
	logic [15:0] cnt_dec;
	logic [15:0] cnt_d;
	logic        buzz_q;
	logic        buzz_d;
	logic        full;
	logic        enq_ok;
	logic        pop_ok;
	logic        out_buzz_q;
	logic        out_acc_q;
	logic [3:0]  out_cnt_q;
	logic        out_busy_q;

	function automatic qidx_t idx_inc(input qidx_t idx);
		return (idx == QidxW'(QueueDepth - 1)) ? '0 : idx + 1'b1;
	endfunction

	// Input capture; zero repeat, delay and gap are stored as one.
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q        <= opcode;
			req_q.times <= (repeat_count == 8'd0) ? 8'd1 : repeat_count;
			req_q.width <= on_ticks;
			req_q.delay <= (delay_ticks == 16'd0) ? 16'd1 : delay_ticks;
			req_q.gap   <= (gap_ticks == 16'd0) ? 16'd1 : gap_ticks;
		end
	end

	// Queue storage with a registered read of the head entry.
	always_ff @(posedge clk) begin
		if (cmd.commit && enq_ok) begin
			mem[tail_q] <= req_q;
		end
		rd_q <= mem[head_q];
	end

	assign full    = (count_q == QcntW'(QueueDepth));
	assign enq_ok  = cmd.enqueue && !full;
	assign pop_ok  = cmd.pop && (count_q != '0);
	assign cnt_dec = (cnt_q != 16'd0) ? cnt_q - 16'd1 : cnt_q;

	// Next values of the countdown, buzzer and fill count.
	always_comb begin
		cnt_d = cmd.tick ? cnt_dec : cnt_q;
		case (cmd.load)
			CL_DELAY: cnt_d = rd_q.delay;
			CL_WIDTH: cnt_d = rd_q.width;
			CL_GAP:   cnt_d = rd_q.gap;
			default:  cnt_d = cmd.tick ? cnt_dec : cnt_q;
		endcase
		buzz_d = buzz_q;
		if (cmd.buzz_set) begin
			buzz_d = 1'b1;
		end else if (cmd.buzz_clr) begin
			buzz_d = 1'b0;
		end
		count_d = count_q;
		if (enq_ok) begin
			count_d = count_q + 1'b1;
		end else if (pop_ok) begin
			count_d = count_q - 1'b1;
		end
	end

	// State registers, updated once per executed item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			rep_q   <= '0;
			cnt_q   <= '0;
			buzz_q  <= 1'b0;
		end else if (cmd.commit) begin
			count_q <= count_d;
			cnt_q   <= cnt_d;
			buzz_q  <= buzz_d;
			if (enq_ok) begin
				tail_q <= idx_inc(tail_q);
			end
			if (pop_ok) begin
				head_q <= idx_inc(head_q);
				rep_q  <= '0;
			end else if (cmd.rep_next) begin
				rep_q <= rep_q + 8'd1;
			end
		end
	end

	// Result register.
	always_ff @(posedge clk) begin
		if (cmd.commit) begin
			out_buzz_q <= buzz_d;
			out_acc_q  <= enq_ok;
			out_cnt_q  <= 4'(count_d);
			out_busy_q <= cmd.busy;
		end
	end

	assign stat.is_enq     = (op_q == OP_ENQ);
	assign stat.cnt_zero   = (cnt_dec == 16'd0);
	assign stat.q_nonempty = (count_q != '0);
	assign stat.last_rep   = !(({1'b0, rep_q} + 9'd1) < {1'b0, rd_q.times});

	assign buzzer_on   = out_buzz_q;
	assign accepted    = out_acc_q;
	assign queue_count = out_cnt_q;
	assign busy_res    = out_busy_q;

endmodule

>>> src/bps_ctrl.sv
// Controller: transfer handshake and the seven-phase buzzer sequencer.
module bps_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	output logic              req_ready,
	output logic              rsp_valid,
	input  logic              rsp_ready,
	input  bps_pkg::dp_stat_t stat,
	output bps_pkg::dp_cmd_t  cmd
);
	import bps_pkg::*;

	ctl_state_t state_q;
	ctl_state_t state_d;
	phase_t     phase_q;
	phase_t     phase_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free  = !out_valid_q || rsp_ready;
	assign req_ready = (state_q == CS_IDLE);
	assign rsp_valid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= CS_IDLE;
			phase_q     <= PH_INIT;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			phase_q <= phase_d;
			if (cmd.commit) begin
				out_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Next state and datapath commands.
	always_comb begin
		state_d = state_q;
		phase_d = phase_q;
		cmd     = '0;
		unique case (state_q)
			CS_IDLE: begin
				if (req_valid) begin
					cmd.capture = 1'b1;
					state_d     = CS_EXEC;
				end
			end
			CS_EXEC: begin
				if (out_free) begin
					cmd.commit = 1'b1;
					state_d    = CS_IDLE;
					if (stat.is_enq) begin
						cmd.enqueue = 1'b1;
					end else begin
						// One tick: the countdown steps first, then the phase acts.
						cmd.tick = 1'b1;
						unique case (phase_q)
							PH_INIT: begin
								cmd.buzz_clr = 1'b1;
								phase_d      = PH_IDLE;
							end
							PH_IDLE: begin
								if (stat.q_nonempty) begin
									cmd.load = CL_DELAY;
									phase_d  = PH_DELAY;
								end
							end
							PH_DELAY: begin
								if (stat.cnt_zero) begin
									phase_d = PH_TURN_ON;
								end
							end
							PH_TURN_ON: begin
								cmd.buzz_set = 1'b1;
								cmd.load     = CL_WIDTH;
								phase_d      = PH_BEEPING;
							end
							PH_BEEPING: begin
								if (stat.cnt_zero) begin
									phase_d = PH_TURN_OFF;
								end
							end
							PH_TURN_OFF: begin
								cmd.buzz_clr = 1'b1;
								cmd.load     = CL_GAP;
								phase_d      = PH_INTERLUDE;
							end
							PH_INTERLUDE: begin
								if (stat.cnt_zero) begin
									if (stat.last_rep) begin
										cmd.pop = 1'b1;
									end else begin
										cmd.rep_next = 1'b1;
									end
									phase_d = PH_IDLE;
								end
							end
							default: begin
								phase_d = PH_INIT;
							end
						endcase
					end
				end
			end
			default: begin
				state_d = CS_IDLE;
			end
		endcase
		cmd.busy = (phase_d != PH_INIT) && (phase_d != PH_IDLE);
	end

endmodule

>>> src/bps_checker.sv
// Port-level checker for the beep pattern sequencer, bound to the top level.
`include "beep_pattern_sequencer_top_macros.svh"

module bps_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        req_valid,
	input logic        req_ready,
	input logic        rsp_valid,
	input logic        rsp_ready,
	input logic        buzzer_on,
	input logic        accepted,
	input logic [3:0]  queue_count,
	input logic        busy_res
);

	// An idle or initializing sequencer never leaves the buzzer on.
	`BPS_ASSERT(a_idle_quiet, rsp_valid && !busy_res |-> !buzzer_on, "buzzer on while idle")

	// A stored request leaves at least one entry pending.
	`BPS_ASSERT(a_acc_count, rsp_valid && accepted |-> queue_count != 4'd0, "stored but queue empty")

	// After a request transfer the block works on it before taking another.
	`BPS_ASSERT(a_one_at_a_time, req_valid && req_ready |=> !req_ready, "second request taken early")

	// A stalled result holds its value.
	property p_rsp_hold;
		rsp_valid && !rsp_ready |=> rsp_valid && $stable(buzzer_on) && $stable(accepted)
			&& $stable(queue_count) && $stable(busy_res);
	endproperty
	`BPS_ASSERT(a_rsp_hold, p_rsp_hold, "stalled result changed")

	// No result is shown while reset is held.
	`BPS_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !rsp_valid, "result during reset")

endmodule

bind beep_pattern_sequencer_top bps_checker u_bps_checker (.*);
